// ----- design/bmp24_pkg.sv -----
package bmp24_pkg;

  // file layout
  localparam int unsigned HEADER_BYTES = 54;
  localparam int unsigned HDR_IDX_W    = 6;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_LOADED = 2'd1;
  localparam logic [1:0] STAT_TOO_LARGE  = 2'd2;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // byte lanes of a stored pixel, in file order
  localparam logic [1:0] CHAN_BLUE  = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_RED   = 2'd2;

  typedef enum logic {
    PHASE_HEADER,
    PHASE_PIXELS
  } phase_t;

  // image geometry, kept ready for the sequencer
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] total;     // width * height
    logic [31:0] size;      // file size in bytes, low 32 bits
    logic [17:0] line;      // width * 3
    logic [17:0] rowbytes;  // line rounded up to 4
    logic        restart;   // register write this cycle
  } geom_t;

  // what the first stage hands to the result register
  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic       from_store;
    logic [1:0] chan;
    logic [7:0] hdr_byte;
  } stage_t;

  // one byte of the 54-byte header
  function automatic logic [7:0] header_byte(input logic [HDR_IDX_W-1:0] idx,
                                             input logic [31:0] size,
                                             input logic [15:0] w,
                                             input logic [15:0] h);
    logic [7:0] b;
    case (idx)
      6'd0:    b = 8'd66;
      6'd1:    b = 8'd77;
      6'd2:    b = size[7:0];
      6'd3:    b = size[15:8];
      6'd4:    b = size[23:16];
      6'd5:    b = size[31:24];
      6'd10:   b = 8'd54;
      6'd14:   b = 8'd40;
      6'd18:   b = w[7:0];
      6'd19:   b = w[15:8];
      6'd22:   b = h[7:0];
      6'd23:   b = h[15:8];
      6'd26:   b = 8'd1;
      6'd28:   b = 8'd24;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- design/bmp24_regs.sv -----
module bmp24_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bmp24_pkg::geom_t    geo
);
  import bmp24_pkg::*;

  logic [15:0] width;
  logic [15:0] height;
  logic [31:0] total;
  logic [31:0] size;
  logic [17:0] line;
  logic [17:0] rowbytes;

  logic        wr;
  logic [15:0] width_next;
  logic [15:0] height_next;
  logic [17:0] line_next;
  logic [17:0] rowbytes_next;
  logic [33:0] size_prod;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // new register values, with the other register as it stands
  always_comb begin
    width_next  = width;
    height_next = height;
    if (wr && paddr[2] == REG_WIDTH) begin
      width_next = pwdata[15:0];
    end
    if (wr && paddr[2] == REG_HEIGHT) begin
      height_next = pwdata[15:0];
    end
  end

  // derived geometry, at most one multiply each
  assign line_next     = 18'(width_next) * 18'd3;
  assign rowbytes_next = (line_next + 18'd3) & ~18'd3;
  assign size_prod     = 34'(rowbytes_next) * 34'(height_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      width    <= 16'd1;
      height   <= 16'd1;
      total    <= 32'd1;
      size     <= 32'(HEADER_BYTES) + 32'd4;
      line     <= 18'd3;
      rowbytes <= 18'd4;
    end else if (wr) begin
      width    <= width_next;
      height   <= height_next;
      total    <= 32'(width_next) * 32'(height_next);
      size     <= size_prod[31:0] + 32'(HEADER_BYTES);
      line     <= line_next;
      rowbytes <= rowbytes_next;
    end
  end

  // register read back
  assign prdata = (paddr[2] == REG_HEIGHT) ? {16'd0, height} : {16'd0, width};

  assign geo.width    = width;
  assign geo.height   = height;
  assign geo.total    = total;
  assign geo.size     = size;
  assign geo.line     = line;
  assign geo.rowbytes = rowbytes;
  assign geo.restart  = wr;

endmodule

// ----- design/bmp24_store.sv -----
module bmp24_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data
);

  logic [23:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // one registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/bmp24_ctrl.sv -----
module bmp24_ctrl #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned AW         = 16,
  parameter int unsigned CW         = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  bmp24_pkg::geom_t    geo,
  input  logic                accept,
  input  logic                req_type,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output bmp24_pkg::stage_t   info
);
  import bmp24_pkg::*;

  // sequencer state
  phase_t               phase, phase_next;
  logic [CW-1:0]        load_count, load_count_next;
  logic [HDR_IDX_W-1:0] header_index, header_index_next;
  logic [15:0]          row_index, row_index_next;
  logic [17:0]          row_byte_index, row_byte_index_next;
  logic [1:0]           chan, chan_next;
  logic [AW-1:0]        addr, addr_next;
  logic [AW-1:0]        row_start, row_start_next;

  logic        too_large;
  logic        not_loaded;
  logic        load_ok;
  logic        fetch_ok;
  logic        in_line;
  logic        hdr_done;
  logic        row_done;
  logic        img_done;
  logic        last;
  logic [31:0] first_row;

  // status tests
  assign too_large  = geo.total > 32'(MAX_PIXELS);
  assign not_loaded = 32'(load_count) < geo.total;
  assign load_ok    = not_loaded && (load_count < CW'(MAX_PIXELS));
  assign fetch_ok   = accept && req_type && !too_large && !not_loaded;

  // position tests
  assign in_line   = row_byte_index < geo.line;
  assign hdr_done  = header_index == HDR_IDX_W'(HEADER_BYTES - 1);
  assign row_done  = (19'(row_byte_index) + 19'd1) >= 19'(geo.rowbytes);
  assign img_done  = (17'(row_index) + 17'd1) >= 17'(geo.height);
  assign first_row = geo.total - 32'(geo.width);

  assign last = fetch_ok && ((phase == PHASE_HEADER) ? (hdr_done && geo.total == 32'd0)
                                                     : (row_done && img_done));

  // next state
  always_comb begin
    phase_next          = phase;
    load_count_next     = load_count;
    header_index_next   = header_index;
    row_index_next      = row_index;
    row_byte_index_next = row_byte_index;
    chan_next           = chan;
    addr_next           = addr;
    row_start_next      = row_start;
    if (geo.restart || last) begin
      phase_next          = PHASE_HEADER;
      load_count_next     = '0;
      header_index_next   = '0;
      row_index_next      = '0;
      row_byte_index_next = '0;
      chan_next           = CHAN_BLUE;
    end else if (accept && !req_type) begin
      if (load_ok) begin
        load_count_next = load_count + CW'(1);
      end
    end else if (fetch_ok) begin
      case (phase)
        PHASE_HEADER: begin
          header_index_next = header_index + HDR_IDX_W'(1);
          if (hdr_done) begin
            header_index_next   = '0;
            row_index_next      = '0;
            row_byte_index_next = '0;
            chan_next           = CHAN_BLUE;
            addr_next           = first_row[AW-1:0];
            row_start_next      = first_row[AW-1:0];
            phase_next          = PHASE_PIXELS;
          end
        end
        PHASE_PIXELS: begin
          if (in_line) begin
            if (chan == CHAN_RED) begin
              chan_next = CHAN_BLUE;
              addr_next = addr + AW'(1);
            end else begin
              chan_next = chan + 2'd1;
            end
          end
          row_byte_index_next = row_byte_index + 18'd1;
          if (row_done) begin
            row_byte_index_next = '0;
            row_index_next      = row_index + 16'd1;
            chan_next           = CHAN_BLUE;
            row_start_next      = row_start - AW'(geo.width);
            addr_next           = row_start - AW'(geo.width);
          end
        end
        default: begin
          phase_next = PHASE_HEADER;
        end
      endcase
    end
  end

  // outputs to the store and the first stage
  always_comb begin
    wr_en   = accept && !req_type && load_ok;
    wr_addr = load_count[AW-1:0];
    rd_en   = accept && req_type;
    rd_addr = addr;

    info.last       = last;
    info.chan       = chan;
    info.from_store = fetch_ok && phase == PHASE_PIXELS && in_line;
    info.hdr_byte   = 8'd0;
    if (fetch_ok && phase == PHASE_HEADER) begin
      info.hdr_byte = header_byte(header_index, geo.size, geo.width, geo.height);
    end
    if (too_large) begin
      info.status = STAT_TOO_LARGE;
    end else if (not_loaded) begin
      info.status = STAT_NOT_LOADED;
    end else begin
      info.status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_HEADER;
      load_count     <= '0;
      header_index   <= '0;
      row_index      <= '0;
      row_byte_index <= '0;
      chan           <= CHAN_BLUE;
      addr           <= '0;
      row_start      <= '0;
    end else begin
      phase          <= phase_next;
      load_count     <= load_count_next;
      header_index   <= header_index_next;
      row_index      <= row_index_next;
      row_byte_index <= row_byte_index_next;
      chan           <= chan_next;
      addr           <= addr_next;
      row_start      <= row_start_next;
    end
  end

endmodule

// ----- design/rgb_to_bmp24_encoder_core.sv -----
// 24-bit BMP file encoder
//
// Input channel (in_valid/in_ready): req_type 0 loads one pixel (red, green,
// blue) in top-down raster order into the pixel store; req_type 1 fetches the
// next byte of the BMP file. A load gives no output item; a fetch gives one.
// Output channel (out_valid/out_ready): data_byte, last_byte, status. Status 1
// means the image is not fully loaded, 2 that width*height exceeds MAX_PIXELS;
// both return no data and leave the read position where it is.
// The file is the 54-byte header, then the rows bottom to top in B,G,R order,
// each padded to a multiple of 4 bytes. After the byte with last_byte set the
// block clears its load count and expects a new image.
// A fetch's item passes through the store read register, then the result
// register. Throughput: one item per cycle, set by the
// single read and single write port of the pixel store.
// When the receiver stalls, the result register holds and the first stage
// keeps one fetch; in_ready falls only while both are full.
// Reset: width and height become 1, the block is at the start of the header
// with nothing loaded. The pixel store is not cleared. APB writes to width
// (0x0) or height (0x4) restart the block in the same way.
module rgb_to_bmp24_encoder_core #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        last_byte,
  output logic [1:0]  status
);
  import bmp24_pkg::*;

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

  geom_t          geo;
  stage_t         info;
  stage_t         s1;
  logic           s1_valid;
  logic           adv;
  logic           accept;
  logic           wr_en;
  logic           rd_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [23:0]    rd_data;
  logic [7:0]     byte_sel;

  bmp24_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geo     (geo)
  );

  bmp24_ctrl #(
    .MAX_PIXELS (MAX_PIXELS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .geo      (geo),
    .accept   (accept),
    .req_type (req_type),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .info     (info)
  );

  bmp24_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({red, green, blue}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // pipeline flow
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv || !s1_valid;
  assign accept   = in_valid && in_ready;

  // first stage: one fetch item beside the store read register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && req_type;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1 <= info;
    end
  end

  // byte lane of the stored pixel
  always_comb begin
    case (s1.chan)
      CHAN_BLUE:  byte_sel = rd_data[7:0];
      CHAN_GREEN: byte_sel = rd_data[15:8];
      CHAN_RED:   byte_sel = rd_data[23:16];
      default:    byte_sel = 8'd0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      status    <= s1.status;
      last_byte <= (s1.status == STAT_OK) && s1.last;
      if (s1.status != STAT_OK) begin
        data_byte <= 8'd0;
      end else if (s1.from_store) begin
        data_byte <= byte_sel;
      end else begin
        data_byte <= s1.hdr_byte;
      end
    end
  end

  // checks
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> data_byte == 8'd0 && !last_byte)
    else $error("error status item carries data");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && s1_valid)
    else $error("input stalled without a full pipeline");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid)
    else $error("first stage item lost during stall");

endmodule
